/* sv/frqwt_pkg.sv */
// Shared types, codes and constants of the fenced recycle queue with trim.
`default_nettype none

package frqwt_pkg;

   // Default sizing handed to the top level parameters
   localparam int DEF_QUEUE_DEPTH   = 128;
   localparam int DEF_KEEP_ELIGIBLE = 64;

   // Results per allocate, including the hit or miss result
   localparam int MAX_RESULTS = 64;
   localparam int DROP_W      = $clog2(MAX_RESULTS);

   // Field widths
   localparam int CMD_W      = 2;
   localparam int SEQ_W      = 32;
   localparam int HANDLE_W   = 16;
   localparam int KIND_W     = 3;
   localparam int REQ_DATA_W = 56;
   localparam int ENTRY_W    = SEQ_W + HANDLE_W;

   // Command codes on the request channel
   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_UPDATE  = 2'd1,
      CMD_RECYCLE = 2'd2
   } cmd_type;

   // Result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_HIT      = 3'd0,
      KIND_MISS     = 3'd1,
      KIND_RELEASED = 3'd2,
      KIND_PUSHED   = 3'd3,
      KIND_FULL     = 3'd4,
      KIND_ABSORBED = 3'd5
   } kind_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_A_READ,
      ST_A_FRONT,
      ST_A_SCAN,
      ST_A_TRIM_CHK,
      ST_A_TRIM_RD,
      ST_A_TRIM_EVAL,
      ST_EXEC
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic cap;
      logic rd_head;
      logic front_eval;
      logic scan_step;
      logic trim_load;
      logic trim_rd;
      logic trim_take;
      logic emit;
      logic emit_last;
      logic exec;
   } ctl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_free;
      logic front_ok;
      logic scan_done;
      logic trim_more;
      logic exec_has_result;
   } dp_stat_type;

endpackage

`default_nettype wire

/* sv/fenced_recycle_queue_with_trim_top.sv */
// Top level of the fenced recycle queue with trim.
//
// A FIFO of buffer handles, each tagged with the sequence at which it is
// released, held in one RAM of QUEUE_DEPTH entries. One request is worked at
// a time; the next request is taken as soon as the previous one has placed its
// last result in the output register. Update and recycle are accepted and
// then executed. Allocate reads and checks the front entry, scans the N
// entries left queued after the front check, and then releases R entries by
// trim (at most MAX_RESULTS-1); the trim stops early at a front entry that is
// not yet released. The eligibility count reads every queued entry through
// the single RAM read port, one per cycle, and then drains the read pipe, and
// each trim release needs a RAM read of the front entry. Output stalls hold
// the trim and execute steps. The current name loads from the csr write at
// once; csr_ready is always high.
`default_nettype none

module fenced_recycle_queue_with_trim_top #(
   parameter int QUEUE_DEPTH   = frqwt_pkg::DEF_QUEUE_DEPTH,
   parameter int KEEP_ELIGIBLE = frqwt_pkg::DEF_KEEP_ELIGIBLE
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [frqwt_pkg::REQ_DATA_W-1:0]  req_tdata,  // seq[31:0], handle[47:32], owned[48]
   input  wire logic [frqwt_pkg::CMD_W-1:0]       req_tuser,  // cmd[1:0]
   // Result channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [frqwt_pkg::HANDLE_W-1:0]         rsp_tdata,  // handle_out[15:0]
   output logic [frqwt_pkg::KIND_W-1:0]           rsp_tuser,  // kind[2:0]
   output logic                                   rsp_tlast,
   // Configuration write channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [frqwt_pkg::HANDLE_W-1:0]    csr_data
);

   frqwt_pkg::ctl_cmd_type ctl;
   frqwt_pkg::dp_stat_type stat;

   frqwt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_cmd   (req_tuser),
      .in_ready (req_tready),
      .stat     (stat),
      .ctl      (ctl)
   );

   frqwt_dpath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .KEEP_ELIGIBLE (KEEP_ELIGIBLE)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* sv/frqwt_ram.sv */
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module frqwt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read; read data holds when no read is issued
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

/* sv/frqwt_ctrl.sv */
// Controller state machine of the fenced recycle queue with trim.
`default_nettype none

module frqwt_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [frqwt_pkg::CMD_W-1:0]   in_cmd,
   output logic                               in_ready,
   input  wire frqwt_pkg::dp_stat_type        stat,
   output frqwt_pkg::ctl_cmd_type             ctl
);

   frqwt_pkg::state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         frqwt_pkg::ST_IDLE: begin
            if (in_valid) begin
               if (in_cmd == frqwt_pkg::CMD_ALLOC) begin
                  state_in = frqwt_pkg::ST_A_READ;
               end else if (in_cmd == frqwt_pkg::CMD_UPDATE ||
                            in_cmd == frqwt_pkg::CMD_RECYCLE) begin
                  state_in = frqwt_pkg::ST_EXEC;
               end
            end
         end
         frqwt_pkg::ST_A_READ:     state_in = frqwt_pkg::ST_A_FRONT;
         frqwt_pkg::ST_A_FRONT:    state_in = frqwt_pkg::ST_A_SCAN;
         frqwt_pkg::ST_A_SCAN: begin
            if (stat.scan_done) begin
               state_in = frqwt_pkg::ST_A_TRIM_CHK;
            end
         end
         frqwt_pkg::ST_A_TRIM_CHK: state_in = frqwt_pkg::ST_A_TRIM_RD;
         frqwt_pkg::ST_A_TRIM_RD: begin
            if (stat.trim_more) begin
               state_in = frqwt_pkg::ST_A_TRIM_EVAL;
            end else if (stat.out_free) begin
               state_in = frqwt_pkg::ST_IDLE;
            end
         end
         frqwt_pkg::ST_A_TRIM_EVAL: begin
            if (stat.out_free) begin
               state_in = stat.front_ok ? frqwt_pkg::ST_A_TRIM_RD : frqwt_pkg::ST_IDLE;
            end
         end
         frqwt_pkg::ST_EXEC: begin
            if (stat.out_free || !stat.exec_has_result) begin
               state_in = frqwt_pkg::ST_IDLE;
            end
         end
         default: state_in = frqwt_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      ctl      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         frqwt_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            ctl.cap  = in_valid;
         end
         frqwt_pkg::ST_A_READ:     ctl.rd_head    = 1'b1;
         frqwt_pkg::ST_A_FRONT:    ctl.front_eval = 1'b1;
         frqwt_pkg::ST_A_SCAN:     ctl.scan_step  = !stat.scan_done;
         frqwt_pkg::ST_A_TRIM_CHK: ctl.trim_load  = 1'b1;
         frqwt_pkg::ST_A_TRIM_RD: begin
            if (stat.trim_more) begin
               ctl.trim_rd = 1'b1;
            end else if (stat.out_free) begin
               ctl.emit      = 1'b1;
               ctl.emit_last = 1'b1;
            end
         end
         frqwt_pkg::ST_A_TRIM_EVAL: begin
            if (stat.out_free) begin
               ctl.emit      = 1'b1;
               ctl.emit_last = !stat.front_ok;
               ctl.trim_take = stat.front_ok;
            end
         end
         frqwt_pkg::ST_EXEC: begin
            ctl.exec = stat.out_free || !stat.exec_has_result;
         end
         default: ctl = '0;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= frqwt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* sv/frqwt_dpath.sv */
// Datapath of the fenced recycle queue: queue pointers, entry RAM, scan and output register.
`default_nettype none

module frqwt_dpath #(
   parameter int QUEUE_DEPTH   = frqwt_pkg::DEF_QUEUE_DEPTH,
   parameter int KEEP_ELIGIBLE = frqwt_pkg::DEF_KEEP_ELIGIBLE
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire frqwt_pkg::ctl_cmd_type            ctl,
   output frqwt_pkg::dp_stat_type                 stat,
   input  wire logic [frqwt_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic [frqwt_pkg::CMD_W-1:0]       req_tuser,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [frqwt_pkg::HANDLE_W-1:0]    csr_data,
   input  wire logic                              rsp_tready,
   output logic                                   rsp_tvalid,
   output logic [frqwt_pkg::HANDLE_W-1:0]         rsp_tdata,
   output logic [frqwt_pkg::KIND_W-1:0]           rsp_tuser,
   output logic                                   rsp_tlast
);

   localparam int IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int KEEP_W = $clog2(KEEP_ELIGIBLE + 1);
   localparam int CMP_A  = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;
   localparam int CMP_W  = (CMP_A > frqwt_pkg::DROP_W) ? CMP_A : frqwt_pkg::DROP_W;
   localparam int SEQ_W  = frqwt_pkg::SEQ_W;
   localparam int HND_W  = frqwt_pkg::HANDLE_W;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   // Control state
   logic [IDX_W-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [HND_W-1:0]   name_ff, name_in;
   logic               owned_name_ff, owned_name_in;
   logic               rv_ff, rv_in;
   logic               rsp_valid_ff, rsp_valid_in;
   // Payload state
   logic [frqwt_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [HND_W-1:0]   hnd_ff, hnd_in;
   logic               own_ff, own_in;
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]   scan_left_ff, scan_left_in;
   logic [CNT_W-1:0]   elig_ff, elig_in;
   logic [frqwt_pkg::DROP_W-1:0] drop_ff, drop_in;
   frqwt_pkg::kind_type pend_kind_ff, pend_kind_in, rsp_kind_ff, rsp_kind_in;
   logic [HND_W-1:0]   pend_hnd_ff, pend_hnd_in, rsp_hnd_ff, rsp_hnd_in;
   logic               rsp_last_ff, rsp_last_in;

   // Entry RAM ports
   logic                            ram_we, ram_re;
   logic [IDX_W-1:0]                ram_waddr, ram_raddr;
   logic [frqwt_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
   logic [SEQ_W-1:0]                rd_seq;
   logic [HND_W-1:0]                rd_hnd;

   // Execute decode for update and recycle
   logic               is_update, absorb, push_need, is_full, has_result;
   logic [HND_W-1:0]   push_hnd;
   frqwt_pkg::kind_type exec_kind;
   logic [CMP_W-1:0]   elig_x, surplus;
   logic               out_free, rd_elig;

   assign rd_seq   = ram_rdata[frqwt_pkg::ENTRY_W-1:HND_W];
   assign rd_hnd   = ram_rdata[HND_W-1:0];
   assign rd_elig  = rd_seq <= seq_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign is_update  = cmd_ff == frqwt_pkg::CMD_UPDATE;
   assign absorb     = !is_update && owned_name_ff && (name_ff == hnd_ff);
   assign push_need  = is_update ? !owned_name_ff : !absorb;
   assign has_result = !(is_update && owned_name_ff);
   assign is_full    = count_ff == CNT_W'(QUEUE_DEPTH);
   assign push_hnd   = is_update ? name_ff : hnd_ff;
   assign exec_kind  = absorb ? frqwt_pkg::KIND_ABSORBED :
                       is_full ? frqwt_pkg::KIND_FULL : frqwt_pkg::KIND_PUSHED;

   assign elig_x  = CMP_W'(elig_ff);
   assign surplus = elig_x - CMP_W'(KEEP_ELIGIBLE);

   // Status to controller
   always_comb begin
      stat.out_free        = out_free;
      stat.front_ok        = rd_elig;
      stat.scan_done       = (scan_left_ff == '0) && !rv_ff;
      stat.trim_more       = (drop_ff != '0) && (count_ff != '0);
      stat.exec_has_result = has_result;
   end

   // Drive RAM ports
   always_comb begin
      ram_we    = ctl.exec && push_need && !is_full;
      ram_waddr = tail_ff;
      ram_wdata = {seq_ff, push_hnd};
      ram_re    = ctl.rd_head || ctl.trim_rd || (ctl.scan_step && scan_left_ff != '0);
      ram_raddr = ctl.scan_step ? scan_idx_ff : head_ff;
   end

   // Next-state logic of the datapath registers
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      name_in       = name_ff;
      owned_name_in = owned_name_ff;
      rv_in         = rv_ff;
      cmd_in        = cmd_ff;
      seq_in        = seq_ff;
      hnd_in        = hnd_ff;
      own_in        = own_ff;
      scan_idx_in   = scan_idx_ff;
      scan_left_in  = scan_left_ff;
      elig_in       = elig_ff;
      drop_in       = drop_ff;
      pend_kind_in  = pend_kind_ff;
      pend_hnd_in   = pend_hnd_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_hnd_in    = rsp_hnd_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      // Capture the accepted request
      if (ctl.cap) begin
         cmd_in = req_tuser;
         seq_in = req_tdata[SEQ_W-1:0];
         hnd_in = req_tdata[SEQ_W+HND_W-1:SEQ_W];
         own_in = req_tdata[SEQ_W+HND_W];
      end

      // Decide hit or miss, pop on hit, start the eligibility scan
      if (ctl.front_eval) begin
         elig_in = '0;
         rv_in   = 1'b0;
         if (count_ff != '0 && rd_elig) begin
            pend_kind_in = frqwt_pkg::KIND_HIT;
            pend_hnd_in  = rd_hnd;
            head_in      = next_slot(head_ff);
            count_in     = count_ff - 1'b1;
            scan_idx_in  = next_slot(head_ff);
            scan_left_in = count_ff - 1'b1;
         end else begin
            pend_kind_in = frqwt_pkg::KIND_MISS;
            pend_hnd_in  = '0;
            scan_idx_in  = head_ff;
            scan_left_in = count_ff;
         end
      end

      // Issue one scan read a cycle and count last cycle's entry
      if (ctl.scan_step) begin
         rv_in = scan_left_ff != '0;
         if (scan_left_ff != '0) begin
            scan_idx_in  = next_slot(scan_idx_ff);
            scan_left_in = scan_left_ff - 1'b1;
         end
         if (rv_ff && rd_elig) begin
            elig_in = elig_ff + 1'b1;
         end
      end

      // Bound the number of trim releases
      if (ctl.trim_load) begin
         if (elig_x <= CMP_W'(KEEP_ELIGIBLE)) begin
            drop_in = '0;
         end else if (surplus > CMP_W'(frqwt_pkg::MAX_RESULTS - 1)) begin
            drop_in = frqwt_pkg::DROP_W'(frqwt_pkg::MAX_RESULTS - 1);
         end else begin
            drop_in = surplus[frqwt_pkg::DROP_W-1:0];
         end
      end

      // Transfer the pending result to the output register
      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = pend_kind_ff;
         rsp_hnd_in   = pend_hnd_ff;
         rsp_last_in  = ctl.emit_last;
      end

      // Release the eligible front entry
      if (ctl.trim_take) begin
         pend_kind_in = frqwt_pkg::KIND_RELEASED;
         pend_hnd_in  = rd_hnd;
         head_in      = next_slot(head_ff);
         count_in     = count_ff - 1'b1;
         drop_in      = drop_ff - 1'b1;
      end

      // Execute update or recycle
      if (ctl.exec) begin
         if (push_need && !is_full) begin
            tail_in  = next_slot(tail_ff);
            count_in = count_ff + 1'b1;
         end
         if (is_update) begin
            name_in       = hnd_ff;
            owned_name_in = own_ff;
         end else if (absorb) begin
            owned_name_in = 1'b0;
         end
         if (has_result) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = exec_kind;
            rsp_hnd_in   = '0;
            rsp_last_in  = 1'b1;
         end
      end

      // Load the current name from the register write
      if (csr_valid) begin
         name_in = csr_data;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         name_ff       <= '0;
         owned_name_ff <= 1'b0;
         rv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         name_ff       <= name_in;
         owned_name_ff <= owned_name_in;
         rv_ff         <= rv_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      seq_ff       <= seq_in;
      hnd_ff       <= hnd_in;
      own_ff       <= own_in;
      scan_idx_ff  <= scan_idx_in;
      scan_left_ff <= scan_left_in;
      elig_ff      <= elig_in;
      drop_ff      <= drop_in;
      pend_kind_ff <= pend_kind_in;
      pend_hnd_ff  <= pend_hnd_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_hnd_ff   <= rsp_hnd_in;
      rsp_last_ff  <= rsp_last_in;
   end

   frqwt_ram #(
      .WIDTH (frqwt_pkg::ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_hnd_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

/* sv/frqwt_checker.sv */
// Port-level assertions for the fenced recycle queue with trim, and their bind.
`default_nettype none

module frqwt_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [frqwt_pkg::HANDLE_W-1:0] rsp_tdata,
   input wire logic [frqwt_pkg::KIND_W-1:0]   rsp_tuser,
   input wire logic                           rsp_tlast
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Carry a handle only on hit and release results
   a_zero_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != frqwt_pkg::KIND_HIT &&
      rsp_tuser != frqwt_pkg::KIND_RELEASED |-> rsp_tdata == '0)
      else $error("handle on a result kind that carries none");

   // Only allocate yields results that are not last
   a_multi_alloc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
         rsp_tuser == frqwt_pkg::KIND_HIT || rsp_tuser == frqwt_pkg::KIND_MISS ||
         rsp_tuser == frqwt_pkg::KIND_RELEASED)
      else $error("non-last result outside an allocate");

   // A result after a non-last transfer continues the same allocate with a release
   a_trim_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast ##1 rsp_tvalid |->
         rsp_tuser == frqwt_pkg::KIND_RELEASED)
      else $error("allocate run continued with a result other than a release");

   // Drop the result after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind fenced_recycle_queue_with_trim_top frqwt_checker u_frqwt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the fenced recycle queue with trim.
module tb_top;
   import frqwt_pkg::*;

   localparam int RING_DEPTH   = DEF_QUEUE_DEPTH;
   localparam int KEEP_RESERVE = DEF_KEEP_ELIGIBLE;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int QUIET_CYCLES = 16;
   localparam int END_CYCLES   = 300;
   localparam int PRINT_LIMIT  = 100;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

   typedef struct {
      logic [CMD_W-1:0]    cmd;
      logic [SEQ_W-1:0]    seq;
      logic [HANDLE_W-1:0] handle;
      logic                owned;
   } command_type;

   typedef struct {
      kind_type            kind;
      logic [HANDLE_W-1:0] handle;
      logic                last;
   } result_type;

   // Block ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [HANDLE_W-1:0]   rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [HANDLE_W-1:0]   csr_data = '0;

   // Mirror of the handle ring and the current name
   logic [HANDLE_W-1:0] ring_handle [RING_DEPTH];
   logic [SEQ_W-1:0]    ring_tag [RING_DEPTH];
   int                  ring_head = 0;
   int                  ring_tail = 0;
   int                  ring_count = 0;
   logic [HANDLE_W-1:0] name_now = '0;
   logic                name_is_owned = 1'b0;

   command_type command_backlog[$];
   result_type  due_results[$];
   command_type drive_item;
   int       burst_left = 0;
   int       gap_left = 0;
   int       stall_mode = 0;
   int       mode_left = 0;
   int       error_count = 0;
   int       cycle_count = 0;
   logic                name_write_due = 1'b0;
   logic [HANDLE_W-1:0] name_write_value = '0;

   fenced_recycle_queue_with_trim_top #(
      .QUEUE_DEPTH   (RING_DEPTH),
      .KEEP_ELIGIBLE (KEEP_RESERVE)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // seq[31:0], handle[47:32], owned[48]
      .req_tuser  (req_tuser),   // cmd[1:0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // handle_out[15:0]
      .rsp_tuser  (rsp_tuser),   // kind[2:0]
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic flag_error(input string msg);
      if (error_count < PRINT_LIMIT) $display("ERROR cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic bit front_released(input logic [SEQ_W-1:0] seq);
      return ring_count > 0 && ring_tag[ring_head] <= seq;
   endfunction

   function automatic logic [HANDLE_W-1:0] take_front();
      logic [HANDLE_W-1:0] h;
      h = ring_handle[ring_head];
      ring_head = (ring_head + 1) % RING_DEPTH;
      ring_count--;
      return h;
   endfunction

   // Append to the ring; refuse when full
   function automatic kind_type store_entry(input logic [HANDLE_W-1:0] h,
                                            input logic [SEQ_W-1:0] tag);
      if (ring_count >= RING_DEPTH) return KIND_FULL;
      ring_handle[ring_tail] = h;
      ring_tag[ring_tail] = tag;
      ring_tail = (ring_tail + 1) % RING_DEPTH;
      ring_count++;
      return KIND_PUSHED;
   endfunction

   // Work out the results of one accepted command and queue them
   task automatic apply_command(input command_type c);
      result_type outs[$];
      int      ready_count;
      int      drop;
      int      idx;
      if (c.cmd == CMD_ALLOC) begin
         if (front_released(c.seq)) outs = {outs, result_type'{KIND_HIT, take_front(), 1'b0}};
         else outs = {outs, result_type'{KIND_MISS, '0, 1'b0}};
         // count released entries left anywhere in the ring
         ready_count = 0;
         idx = ring_head;
         for (int i = 0; i < ring_count; i++) begin
            if (ring_tag[idx] <= c.seq) ready_count++;
            idx = (idx + 1) % RING_DEPTH;
         end
         // trim the surplus from the front, stop at an unreleased entry
         if (ready_count > KEEP_RESERVE) begin
            drop = ready_count - KEEP_RESERVE;
            while (drop > 0 && outs.size() < MAX_RESULTS && front_released(c.seq)) begin
               outs = {outs, result_type'{KIND_RELEASED, take_front(), 1'b0}};
               drop--;
            end
         end
      end else if (c.cmd == CMD_UPDATE) begin
         if (!name_is_owned)
            outs = {outs, result_type'{store_entry(name_now, c.seq), '0, 1'b0}};
         name_now = c.handle;
         name_is_owned = c.owned;
      end else if (c.cmd == CMD_RECYCLE) begin
         if (name_is_owned && name_now == c.handle) begin
            name_is_owned = 1'b0;
            outs = {outs, result_type'{KIND_ABSORBED, '0, 1'b0}};
         end else begin
            outs = {outs, result_type'{store_entry(c.handle, c.seq), '0, 1'b0}};
         end
      end
      if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
      due_results = {due_results, outs};
   endtask

   // Request driver: bursts with random gaps, hold the item until transfer
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) apply_command(drive_item);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (command_backlog.size() > 0) begin
               drive_item = command_backlog[0];
               command_backlog.delete(0);
               req_tdata  <= {{(REQ_DATA_W-49){1'b0}}, drive_item.owned,
                              drive_item.handle, drive_item.seq};
               req_tuser  <= drive_item.cmd;
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 15);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each transfer with the oldest due result
   always @(posedge clock) begin : result_monitor
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               flag_error($sformatf("result with none due: kind %0d handle %h last %b",
                                    rsp_tuser, rsp_tdata, rsp_tlast));
            end else begin
               want = due_results[0];
               due_results.delete(0);
               if (rsp_tuser !== want.kind || rsp_tdata !== want.handle
                   || rsp_tlast !== want.last)
                  flag_error($sformatf("got kind %0d handle %h last %b, want %0d %h %b",
                                       rsp_tuser, rsp_tdata, rsp_tlast,
                                       want.kind, want.handle, want.last));
            end
         end
         // switch the stall pattern now and then
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 80);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Initial-name write channel
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         name_now = csr_data;
         name_write_due = 1'b0;
         csr_valid <= 1'b0;
      end else if (name_write_due && !csr_valid) begin
         csr_data  <= name_write_value;
         csr_valid <= 1'b1;
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic queue_command(input logic [CMD_W-1:0] cmd, input logic [SEQ_W-1:0] seq,
                                input logic [HANDLE_W-1:0] handle, input logic owned);
      command_backlog = {command_backlog, command_type'{cmd, seq, handle, owned}};
   endtask

   // Wait until every command is taken and every result is in, then settle
   task automatic wait_drained();
      while (command_backlog.size() != 0 || req_tvalid || due_results.size() != 0)
         @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_initial_name(input logic [HANDLE_W-1:0] value);
      name_write_value = value;
      name_write_due = 1'b1;
      while (name_write_due) @(negedge clock);
   endtask

   function automatic logic [SEQ_W-1:0] pick_alloc_seq();
      case ($urandom_range(0, 3))
         0: return '1;
         1: return 32'hC000_0000 + $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   // Mixed traffic: allocs, push runs, own-then-recycle pairs and noise
   task automatic queue_mixed(input int count, input int alloc_pct);
      int                  pick;
      logic [HANDLE_W-1:0] h;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         h = $urandom;
         if (pick < alloc_pct) begin
            queue_command(CMD_ALLOC, pick_alloc_seq(), h, $urandom);
         end else if (pick < alloc_pct + 8) begin
            queue_command(CMD_UPDATE, $urandom, h, 1'b1);
            queue_command(CMD_RECYCLE, $urandom, h, $urandom);
         end else if (pick < alloc_pct + 18) begin
            queue_command(CMD_UPDATE, $urandom, h, $urandom);
         end else if (pick < alloc_pct + 22) begin
            queue_command(CMD_UNKNOWN, $urandom, h, $urandom);
         end else begin
            queue_command(CMD_RECYCLE, $urandom, h, $urandom);
         end
      end
   endtask

   // Stimulus sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_initial_name(16'hFFFF);

      // directed: empty miss, owned and unowned updates, absorb, ignore, hits
      queue_command(CMD_ALLOC,   32'd0,        16'h0000, 1'b0);
      queue_command(CMD_UPDATE,  32'd0,        16'h1234, 1'b0);
      queue_command(CMD_UPDATE,  32'hFFFFFFFF, 16'hFFFF, 1'b1);
      queue_command(CMD_UPDATE,  32'd5,        16'h0000, 1'b0);
      queue_command(CMD_RECYCLE, 32'd10,       16'h0000, 1'b0);
      queue_command(CMD_UPDATE,  32'd7,        16'hABCD, 1'b1);
      queue_command(CMD_RECYCLE, 32'd3,        16'hABCD, 1'b0);
      queue_command(CMD_RECYCLE, 32'd3,        16'hABCD, 1'b1);
      queue_command(CMD_UNKNOWN, 32'hFFFFFFFF, 16'hFFFF, 1'b1);
      queue_command(CMD_UPDATE,  32'd1,        16'h5555, 1'b1);
      queue_command(CMD_RECYCLE, 32'd2,        16'h5556, 1'b0);
      queue_command(CMD_ALLOC,   32'd0,        16'hFFFF, 1'b1);
      queue_command(CMD_ALLOC,   32'd0,        16'h0000, 1'b0);
      queue_command(CMD_ALLOC,   32'hFFFFFFFF, 16'h0000, 1'b0);
      queue_command(CMD_ALLOC,   32'd9,        16'h0000, 1'b0);
      queue_command(CMD_ALLOC,   32'h80000000, 16'h0000, 1'b0);
      queue_command(CMD_RECYCLE, 32'd0,        16'h5555, 1'b0);
      queue_command(CMD_UNKNOWN, 32'd0,        16'h0000, 1'b0);
      wait_drained();

      // fill past full, then trim with mixed and with all-released tags
      write_initial_name($urandom);
      queue_mixed(150, 0);
      queue_command(CMD_UPDATE,  $urandom, $urandom, 1'b0);
      queue_command(CMD_RECYCLE, $urandom, $urandom, 1'b0);
      queue_command(CMD_ALLOC,   32'hC0000000, $urandom, $urandom);
      queue_command(CMD_ALLOC,   32'hFFFFFFFF, $urandom, $urandom);
      queue_command(CMD_ALLOC,   $urandom, $urandom, $urandom);
      wait_drained();

      // allocate-heavy drain
      write_initial_name(16'h0000);
      queue_mixed(30, 50);
      wait_drained();

      // balanced traffic
      write_initial_name($urandom);
      queue_mixed(40, 35);

      while (command_backlog.size() != 0 || req_tvalid || due_results.size() != 0)
         @(negedge clock);
      repeat (END_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
